/* rtl/core/tsrpc_pkg.sv */
// ----------------------------------------------------------------------------
// tsrpc_pkg
// Shared types and constants for the TS-over-RTP PCR and PID classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrpc_pkg;

  // TS header size and the PCR byte window inside a TS packet
  localparam int unsigned TS_HEADER_BYTES = 4;
  localparam logic [7:0]  PCR_FIRST_POS   = 8'(TS_HEADER_BYTES + 2);
  localparam logic [7:0]  PCR_LAST_POS    = 8'(TS_HEADER_BYTES + 7);
  localparam logic [7:0]  PID_HI_POS      = 8'd1;
  localparam logic [7:0]  PID_LO_POS      = 8'd2;

  // register reset values
  localparam logic [7:0]  RTP_HDR_LEN_RST = 8'd12;
  localparam logic [12:0] PCR_PID_RST     = 13'h1000;
  localparam logic [12:0] VIDEO_PID_RST   = 13'h1011;
  localparam logic [12:0] AUDIO_PID_RST   = 13'h1100;

  // ms = (base*300 + ext) / 27000 = base/90 + carry, base/90 = (base>>1)/45
  localparam logic [15:0] EXT_SCALE       = 16'd300;
  localparam logic [15:0] MS_DIVISOR      = 16'd27000;
  localparam logic [13:0] BASE_DIVISOR    = 14'd90;
  // ceil(2^38/45) = 2^32 + DIV45_MAGIC_LO, exact for all 32-bit dividends
  localparam logic [30:0] DIV45_MAGIC_LO  = 31'd1813430637;
  localparam int unsigned DIV45_SHIFT     = 38;

  typedef enum logic [1:0] {
    CFG_RTP_HDR_LEN = 2'd0,
    CFG_PCR_PID     = 2'd1,
    CFG_VIDEO_PID   = 2'd2,
    CFG_AUDIO_PID   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_VIDEO = 2'd1,
    KIND_AUDIO = 2'd2
  } kind_t;

  // summary of one RTP packet, handed to the PCR conversion pipe
  typedef struct packed {
    kind_t       kind;
    logic        found;
    logic        err;
    logic [47:0] raw;
  } pkt_rec_t;

  typedef struct packed {
    kind_t       kind;
    logic        found;
    logic        err;
    logic [31:0] half_base;
    logic [6:0]  base_lo;
    logic [8:0]  ext;
    logic [62:0] prod;
  } mul_stage_t;

  typedef struct packed {
    kind_t       kind;
    logic        found;
    logic        err;
    logic [6:0]  base_lo;
    logic [8:0]  ext;
    logic [26:0] quot;
  } quot_stage_t;

  typedef struct packed {
    kind_t       kind;
    logic        found;
    logic        err;
    logic [8:0]  ext;
    logic [6:0]  rem;
    logic [26:0] quot;
  } rem_stage_t;

endpackage : tsrpc_pkg

`default_nettype wire

/* rtl/core/ts_over_rtp_pcr_and_pid_classifier.sv */
// ----------------------------------------------------------------------------
// ts_over_rtp_pcr_and_pid_classifier
// Walks an RTP packet carrying MPEG-2 TS, classifies it by PID and pulls PCR.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one RTP packet byte per item, in_last_byte on the final byte.
//   cfg_* : register writes (header length, PCR/video/audio PID), always
//           ready; write only while the block is idle.
//   out_* : one result per RTP packet: kind, PCR found, PCR in ms, and a
//           length error when the payload is empty or not whole TS packets.
// Throughput: one byte per cycle while in_ready is high. Per-byte parsing is a position counter
//   and a few compares done in the accepting cycle.
// Pipe: the last byte's summary is registered in s1, then the PCR conversion
//   runs through a 4-register pipe (32x31 reciprocal multiply, add/shift,
//   remainder, carry) ending in the output register that drives out_valid.
// Stall: the conversion pipe is elastic, so bytes keep flowing while a result
//   waits; in_ready drops only when the pipe's first stage cannot drain.
// Reset: rst_n (sync, active low) restores register defaults, clears the
//   parse state and empties the pipe. Parse state also clears after each
//   last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_over_rtp_pcr_and_pid_classifier
  import tsrpc_pkg::*;
#(
  parameter int unsigned TS_PACKET_BYTES = 188
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_packet_kind,
  output logic             out_pcr_found,
  output logic [26:0]      out_pcr_millis,
  output logic             out_length_error
);

  localparam logic [8:0] TS_PKT_LEN = 9'(TS_PACKET_BYTES);

  // configuration
  logic [7:0]  rtp_hdr_len_r;
  logic [12:0] pcr_pid_r, video_pid_r, audio_pid_r;

  // parse state
  logic [7:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [4:0]  pid_hi_r, pid_hi_nxt;
  logic        active_r, active_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic        done_r, done_nxt;
  kind_t       kind_r, kind_nxt;
  logic        seen_r, seen_nxt;

  // pipe
  logic        v1_r, v2_r, v3_r, v4_r, out_valid_r;
  pkt_rec_t    s1_r;
  mul_stage_t  s2_r;
  quot_stage_t s3_r;
  rem_stage_t  s4_r;
  kind_t       out_kind_r;
  logic        out_found_r, out_err_r;
  logic [26:0] out_ms_r;

  logic        accept, push;
  logic        mv1, mv2, mv3, mv4, out_free;
  logic [12:0] pid;
  logic [64:0] quot_sum;
  logic [13:0] a_times_90;
  logic [15:0] rem_scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtp_hdr_len_r <= RTP_HDR_LEN_RST;
      pcr_pid_r     <= PCR_PID_RST;
      video_pid_r   <= VIDEO_PID_RST;
      audio_pid_r   <= AUDIO_PID_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RTP_HDR_LEN: rtp_hdr_len_r <= cfg_data[7:0];
        CFG_PCR_PID:     pcr_pid_r     <= cfg_data;
        CFG_VIDEO_PID:   video_pid_r   <= cfg_data;
        CFG_AUDIO_PID:   audio_pid_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // elastic pipe control
  assign out_free = !out_valid_r || out_ready;
  assign mv4      = v4_r && out_free;
  assign mv3      = v3_r && (!v4_r || mv4);
  assign mv2      = v2_r && (!v3_r || mv3);
  assign mv1      = v1_r && (!v2_r || mv2);
  assign in_ready = !v1_r || mv1;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_last_byte;

  assign pid = {pid_hi_r, in_data_byte};

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    pos_nxt     = pos_r;
    pid_hi_nxt  = pid_hi_r;
    active_nxt  = active_r;
    shift_nxt   = shift_r;
    done_nxt    = done_r;
    kind_nxt    = kind_r;
    seen_nxt    = seen_r;
    if (hdr_cnt_r < rtp_hdr_len_r) begin
      hdr_cnt_nxt = hdr_cnt_r + 8'd1;
    end else begin
      seen_nxt = 1'b1;
      if (pos_r == PID_HI_POS) begin
        pid_hi_nxt = in_data_byte[4:0];
      end else if (pos_r == PID_LO_POS) begin
        if (!done_r && !active_r && pid == pcr_pid_r) active_nxt = 1'b1;
        if (kind_r == KIND_NONE) begin
          if (pid == video_pid_r)      kind_nxt = KIND_VIDEO;
          else if (pid == audio_pid_r) kind_nxt = KIND_AUDIO;
        end
      end
      if (active_nxt && pos_r >= PCR_FIRST_POS && pos_r <= PCR_LAST_POS) begin
        shift_nxt = {shift_r[39:0], in_data_byte};
        if (pos_r == PCR_LAST_POS) begin
          done_nxt   = 1'b1;
          active_nxt = 1'b0;
        end
      end
      if ({1'b0, pos_r} + 9'd1 >= TS_PKT_LEN) begin
        pos_nxt    = 8'd0;
        active_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      hdr_cnt_r <= 8'd0;
      pos_r     <= 8'd0;
      pid_hi_r  <= 5'd0;
      active_r  <= 1'b0;
      shift_r   <= 48'd0;
      done_r    <= 1'b0;
      kind_r    <= KIND_NONE;
      seen_r    <= 1'b0;
    end else if (accept) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      pos_r     <= pos_nxt;
      pid_hi_r  <= pid_hi_nxt;
      active_r  <= active_nxt;
      shift_r   <= shift_nxt;
      done_r    <= done_nxt;
      kind_r    <= kind_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= push || (v1_r && !mv1);
      v2_r        <= mv1  || (v2_r && !mv2);
      v3_r        <= mv2  || (v3_r && !mv3);
      v4_r        <= mv3  || (v4_r && !mv4);
      out_valid_r <= mv4  || (out_valid_r && !out_ready);
    end
  end

  // raw PCR: base = raw[47:15], ext = raw[8:0]
  assign quot_sum   = {1'b0, s2_r.half_base, 32'd0} + {2'b00, s2_r.prod};
  assign a_times_90 = 14'(s3_r.quot[6:0]) * BASE_DIVISOR;
  assign rem_scaled = 16'(s4_r.rem) * EXT_SCALE + 16'(s4_r.ext);

  always_ff @(posedge clk) begin
    if (push) begin
      s1_r.kind  <= kind_nxt;
      s1_r.found <= done_nxt;
      s1_r.err   <= !seen_nxt || (pos_nxt != 8'd0);
      s1_r.raw   <= shift_nxt;
    end
    if (mv1) begin
      s2_r.kind      <= s1_r.kind;
      s2_r.found     <= s1_r.found;
      s2_r.err       <= s1_r.err;
      s2_r.half_base <= s1_r.raw[47:16];
      s2_r.base_lo   <= s1_r.raw[21:15];
      s2_r.ext       <= s1_r.raw[8:0];
      s2_r.prod      <= 63'(s1_r.raw[47:16]) * 63'(DIV45_MAGIC_LO);
    end
    if (mv2) begin
      s3_r.kind    <= s2_r.kind;
      s3_r.found   <= s2_r.found;
      s3_r.err     <= s2_r.err;
      s3_r.base_lo <= s2_r.base_lo;
      s3_r.ext     <= s2_r.ext;
      s3_r.quot    <= quot_sum[DIV45_SHIFT +: 27];
    end
    if (mv3) begin
      s4_r.kind  <= s3_r.kind;
      s4_r.found <= s3_r.found;
      s4_r.err   <= s3_r.err;
      s4_r.ext   <= s3_r.ext;
      // remainder of base/90 is below 128, so low bits suffice
      s4_r.rem   <= s3_r.base_lo - a_times_90[6:0];
      s4_r.quot  <= s3_r.quot;
    end
    if (mv4) begin
      out_kind_r  <= s4_r.kind;
      out_found_r <= s4_r.found;
      out_err_r   <= s4_r.err;
      out_ms_r    <= !s4_r.found ? 27'd0 :
                     s4_r.quot + 27'(rem_scaled >= MS_DIVISOR);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packet_kind  = out_kind_r;
  assign out_pcr_found    = out_found_r;
  assign out_pcr_millis   = out_ms_r;
  assign out_length_error = out_err_r;

endmodule : ts_over_rtp_pcr_and_pid_classifier

`default_nettype wire

/* test/ts_over_rtp_pcr_and_pid_classifier_tb.sv */
// ----------------------------------------------------------------------------
// ts_over_rtp_pcr_and_pid_classifier_tb
// Feeds RTP packets carrying TS packets one byte per item. A local parser
// tracks header skip, TS position, PID match and PCR capture and predicts one
// result per RTP packet. Each output item is checked field by field.
// ----------------------------------------------------------------------------
module ts_over_rtp_pcr_and_pid_classifier_tb;
  import tsrpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TS_PKT_BYTES = 188;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 800000;

  typedef struct packed {
    kind_t       kind;
    logic        found;
    logic [26:0] millis;
    logic        err;
  } pkt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RTP_HDR_LEN;
  logic [12:0] cfg_data = 13'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_packet_kind;
  logic        out_pcr_found;
  logic [26:0] out_pcr_millis;
  logic        out_length_error;

  // register shadow
  logic [7:0]  hdr_len   = RTP_HDR_LEN_RST;
  logic [12:0] pcr_pid   = PCR_PID_RST;
  logic [12:0] video_pid = VIDEO_PID_RST;
  logic [12:0] audio_pid = AUDIO_PID_RST;

  // parse state of the packet in flight
  logic [7:0]  hdr_seen     = 8'd0;
  logic [7:0]  ts_pos       = 8'd0;
  logic [4:0]  pid_hi       = 5'd0;
  logic        pcr_active   = 1'b0;
  logic [47:0] pcr_raw      = 48'd0;
  logic        pcr_done     = 1'b0;
  kind_t       kind_seen    = KIND_NONE;
  logic        payload_seen = 1'b0;

  pkt_result_t pending_results[$];
  logic [7:0]  rtp_bytes[$];

  int error_count       = 0;
  int items_sent        = 0;
  int results_predicted = 0;
  int cycle_count       = 0;
  int tx_idle_pct       = 0;
  int rx_idle_pct       = 0;

  ts_over_rtp_pcr_and_pid_classifier #(
    .TS_PACKET_BYTES(TS_PKT_BYTES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_kind  (out_packet_kind),
    .out_pcr_found    (out_pcr_found),
    .out_pcr_millis   (out_pcr_millis),
    .out_length_error (out_length_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // compare each output item against the oldest prediction
  always @(posedge clk) begin
    pkt_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: kind %0d found %0d ms %0d err %0d",
               out_packet_kind, out_pcr_found, out_pcr_millis, out_length_error);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_packet_kind !== want.kind) begin
          $error("packet_kind: expected %0d, got %0d", want.kind, out_packet_kind);
          error_count++;
        end
        if (out_pcr_found !== want.found) begin
          $error("pcr_found: expected %0d, got %0d", want.found, out_pcr_found);
          error_count++;
        end
        if (out_pcr_millis !== want.millis) begin
          $error("pcr_millis: expected %0d, got %0d", want.millis, out_pcr_millis);
          error_count++;
        end
        if (out_length_error !== want.err) begin
          $error("length_error: expected %0d, got %0d", want.err, out_length_error);
          error_count++;
        end
      end
    end
  end

  function automatic logic [26:0] pcr_to_ms(input logic [47:0] raw);
    logic [63:0] base;
    logic [63:0] ticks;
    base  = {31'd0, raw[47:15]};
    ticks = base * EXT_SCALE + {55'd0, raw[8:0]};
    return 27'(ticks / MS_DIVISOR);
  endfunction

  // byte-level parser; emits the expected result on the last byte
  task automatic track_byte(input logic [7:0] b, input logic last);
    logic [7:0]  pos;
    logic [12:0] pid;
    pkt_result_t res;
    if (hdr_seen < hdr_len) begin
      hdr_seen = hdr_seen + 8'd1;
    end else begin
      pos = ts_pos;
      payload_seen = 1'b1;
      if (pos == PID_HI_POS) begin
        pid_hi = b[4:0];
      end else if (pos == PID_LO_POS) begin
        pid = {pid_hi, b};
        if (!pcr_done && !pcr_active && pid == pcr_pid) pcr_active = 1'b1;
        if (kind_seen == KIND_NONE) begin
          if (pid == video_pid) kind_seen = KIND_VIDEO;
          else if (pid == audio_pid) kind_seen = KIND_AUDIO;
        end
      end
      if (pcr_active && pos >= PCR_FIRST_POS && pos <= PCR_LAST_POS) begin
        pcr_raw = {pcr_raw[39:0], b};
        if (pos == PCR_LAST_POS) begin
          pcr_done   = 1'b1;
          pcr_active = 1'b0;
        end
      end
      if (int'(pos) + 1 >= TS_PKT_BYTES) begin
        ts_pos     = 8'd0;
        pcr_active = 1'b0;
      end else begin
        ts_pos = pos + 8'd1;
      end
    end
    if (last) begin
      res.kind   = kind_seen;
      res.found  = pcr_done;
      res.millis = pcr_done ? pcr_to_ms(pcr_raw) : 27'd0;
      res.err    = !payload_seen || ts_pos != 8'd0;
      pending_results.push_back(res);
      results_predicted++;
      hdr_seen     = 8'd0;
      ts_pos       = 8'd0;
      pid_hi       = 5'd0;
      pcr_active   = 1'b0;
      pcr_raw      = 48'd0;
      pcr_done     = 1'b0;
      kind_seen    = KIND_NONE;
      payload_seen = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    track_byte(b, last);
  endtask

  task automatic send_rtp_packet();
    int n;
    n = rtp_bytes.size();
    for (int i = 0; i < n; i++) send_byte(rtp_bytes[i], i == n - 1);
    rtp_bytes.delete();
  endtask

  // first nbytes of a TS packet with the given PID and PCR field
  function automatic void push_ts_bytes(input logic [12:0] pid, input logic [47:0] raw,
                                        input int nbytes);
    logic [7:0] b;
    for (int pos = 0; pos < nbytes; pos++) begin
      b = 8'($urandom);
      if (pos == 0 && $urandom_range(1)) b = 8'h47;
      if (pos == PID_HI_POS) b = {b[7:5], pid[12:8]};
      if (pos == PID_LO_POS) b = pid[7:0];
      if (pos >= PCR_FIRST_POS && pos <= PCR_LAST_POS)
        b = raw[47 - 8 * (pos - PCR_FIRST_POS) -: 8];
      rtp_bytes.push_back(b);
    end
  endfunction

  function automatic void push_header_bytes(input int n);
    repeat (n) rtp_bytes.push_back(8'($urandom));
  endfunction

  // sender holds off until every pending result is out, then lets the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RTP_HDR_LEN: hdr_len   = value[7:0];
      CFG_PCR_PID:     pcr_pid   = value;
      CFG_VIDEO_PID:   video_pid = value;
      CFG_AUDIO_PID:   audio_pid = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [12:0] hdr, input logic [12:0] pcr,
                               input logic [12:0] video, input logic [12:0] audio);
    wait_idle();
    write_register(CFG_RTP_HDR_LEN, hdr);
    write_register(CFG_PCR_PID, pcr);
    write_register(CFG_VIDEO_PID, video);
    write_register(CFG_AUDIO_PID, audio);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // default header, PCR PID packet cut right after the PCR field
    push_header_bytes(RTP_HDR_LEN_RST);
    push_ts_bytes(PCR_PID_RST, 48'hFFFF_FFFF_FFFF, PCR_LAST_POS + 1);
    send_rtp_packet();
    // last byte lands inside the header
    push_header_bytes(5);
    send_rtp_packet();
  endtask

  task automatic test_pid_extremes();
    // upper data bits set on the header write are dropped
    load_settings(13'h1F00, 13'h1FFF, 13'h0000, 13'h0000);
    push_ts_bytes(13'h1FFF, 48'hFFFF_FFFF_FFFF, PCR_LAST_POS + 1);
    send_rtp_packet();
    push_ts_bytes(13'h1FFF, 48'h0, PCR_LAST_POS + 1);
    send_rtp_packet();
    // video and audio both match: video wins
    push_ts_bytes(13'h0000, 48'h0, 3);
    send_rtp_packet();
    push_ts_bytes(13'h0000, 48'h0, 1);
    send_rtp_packet();
  endtask

  task automatic test_whole_packet();
    // one whole TS packet: no length error, PCR and kind from the same PID
    load_settings(13'h0004, 13'h0100, 13'h1FFF, 13'h0100);
    push_header_bytes(4);
    push_ts_bytes(13'h0100, {$urandom, 16'($urandom)}, TS_PKT_BYTES);
    send_rtp_packet();
    // packet ends on the last header byte: empty payload
    push_header_bytes(4);
    send_rtp_packet();
    wait_idle();
  endtask

  function automatic logic [12:0] pick_pid();
    case ($urandom_range(4))
      0, 4:    return pcr_pid;
      1:       return video_pid;
      2:       return audio_pid;
      default: return 13'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_pcr();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 48'h0;
    if (r == 1) return 48'hFFFF_FFFF_FFFF;
    return {$urandom, 16'($urandom)};
  endfunction

  task automatic send_random_packet();
    int keep;
    // header and the first TS header and PCR field; half are cut short
    push_header_bytes(hdr_len);
    push_ts_bytes(pick_pid(), pick_pcr(), PCR_LAST_POS + 1);
    if ($urandom_range(1)) begin
      keep = $urandom_range(1, rtp_bytes.size());
      while (rtp_bytes.size() > keep) void'(rtp_bytes.pop_back());
    end
    send_rtp_packet();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    logic [12:0] hdr;
    logic [12:0] pcr;
    logic [12:0] video;
    logic [12:0] audio;
    int          start_items;
    int          start_results;
    hdr   = ($urandom_range(99) < 15) ? 13'd0 : 13'($urandom_range(1, 24));
    hdr   = {5'($urandom), hdr[7:0]};
    pcr   = 13'($urandom);
    video = 13'($urandom);
    audio = ($urandom_range(3) == 0) ? video : 13'($urandom);
    if ($urandom_range(4) == 0) pcr = video;
    load_settings(hdr, pcr, video, audio);
    tx_idle_pct   = tx_pct;
    rx_idle_pct   = rx_pct;
    start_items   = items_sent;
    start_results = results_predicted;
    while (items_sent - start_items < 100 || results_predicted - start_results < 4)
      send_random_packet();
  endtask

  initial begin
    tx_idle_pct = 18;
    rx_idle_pct = 59;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_pid_extremes();
    test_whole_packet();
    test_random_traffic(18, 59);
    test_random_traffic(59, 18);
    test_random_traffic(0, 0);
    wait_idle();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
